### design/isfd_pkg.sv
// ----------------------------------------------------------------------------
// IMU serial frame decoder package
// Shared constants, frame kind codes and the frame record passed from the
// frame assembler to the scaling pipeline.
// ----------------------------------------------------------------------------
package isfd_pkg;

  // Frame layout
  localparam int FRAME_LEN = 11;
  localparam int LAST_IDX  = FRAME_LEN - 1;
  localparam int IDX_W     = $clog2(FRAME_LEN);

  localparam logic [7:0] HDR_BYTE  = 8'h55;
  localparam logic [7:0] TYPE_ACC  = 8'h51;
  localparam logic [7:0] TYPE_RATE = 8'h52;
  localparam logic [7:0] TYPE_ANG  = 8'h53;

  typedef enum logic [2:0] {
    KIND_ACC  = 3'd0,
    KIND_RATE = 3'd1,
    KIND_ANG  = 3'd2,
    KIND_UNK  = 3'd3,
    KIND_BAD  = 3'd4
  } kind_t;

  // Field widths
  localparam int RAW_W  = 16;
  localparam int AXIS_W = 28;
  localparam int TEMP_W = 17;

  // Axis scale factors in Q16 units per raw count
  localparam int SCALE_W = 13;
  localparam logic [SCALE_W-1:0] SCALE_ACC  = SCALE_W'(32);
  localparam logic [SCALE_W-1:0] SCALE_RATE = SCALE_W'(4000);
  localparam logic [SCALE_W-1:0] SCALE_ANG  = SCALE_W'(360);
  localparam int PROD_W = AXIS_W + 2;

  // Temperature: trunc(raw * 64 / 85) + offset, divide done by reciprocal.
  localparam int TEMP_PRESHIFT = 6;
  localparam int MAG_W         = RAW_W + TEMP_PRESHIFT;
  localparam int TEMP_DIV      = 85;
  localparam int RECIP_SHIFT   = 30;
  localparam int RECIP_W       = 24;
  localparam logic [RECIP_W-1:0] RECIP_M =
    RECIP_W'((64'd1 << RECIP_SHIFT) / TEMP_DIV);
  localparam int RPROD_W       = MAG_W + RECIP_W;
  localparam int QUO_W         = 15;
  localparam int QUO_MAX       = (32768 * 64) / TEMP_DIV;
  localparam int TEMP_OFFSET   = 9280;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    kind_t                   kind;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
    logic signed [RAW_W-1:0] raw_t;
    logic                    csum_ok;
  } frame_rec_t;

endpackage

### design/isfd_front.sv
// ----------------------------------------------------------------------------
// IMU serial frame decoder - frame assembler
// Hunts for the first header, collects frame bytes, keeps the running
// checksum and classifies each completed frame into a record.
// ----------------------------------------------------------------------------
module isfd_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_rx_byte,
  input  logic                   q_full,
  output logic                   push,
  output isfd_pkg::frame_rec_t   rec
);

  logic                       hunting_r, hunting_nxt;
  logic [isfd_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]                 sum_r, sum_nxt;
  logic [7:0]                 frame_r [isfd_pkg::LAST_IDX];

  logic is_last;
  logic fire;
  logic store;

  assign is_last  = !hunting_r && (idx_r == isfd_pkg::IDX_W'(isfd_pkg::LAST_IDX));
  assign in_ready = !(is_last && q_full);
  assign fire     = in_valid && in_ready;
  assign push     = fire && is_last;
  assign store    = fire && !is_last && (!hunting_r || (in_rx_byte == isfd_pkg::HDR_BYTE));

  always_comb begin
    hunting_nxt = hunting_r;
    idx_nxt     = idx_r;
    sum_nxt     = sum_r;
    if (fire) begin
      if (hunting_r) begin
        if (in_rx_byte == isfd_pkg::HDR_BYTE) begin
          hunting_nxt = 1'b0;
          idx_nxt     = isfd_pkg::IDX_W'(1);
          sum_nxt     = in_rx_byte;
        end
      end else if (is_last) begin
        idx_nxt = '0;
        sum_nxt = '0;
      end else begin
        idx_nxt = idx_r + isfd_pkg::IDX_W'(1);
        sum_nxt = sum_r + in_rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunting_r <= 1'b1;
      idx_r     <= '0;
      sum_r     <= '0;
    end else begin
      hunting_r <= hunting_nxt;
      idx_r     <= idx_nxt;
      sum_r     <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      frame_r[idx_r] <= in_rx_byte;
    end
  end

  // Classification looks at the stored header and type bytes; the incoming
  // byte is the checksum.
  always_comb begin
    if (frame_r[0] != isfd_pkg::HDR_BYTE) begin
      rec.kind = isfd_pkg::KIND_BAD;
    end else begin
      case (frame_r[1])
        isfd_pkg::TYPE_ACC:  rec.kind = isfd_pkg::KIND_ACC;
        isfd_pkg::TYPE_RATE: rec.kind = isfd_pkg::KIND_RATE;
        isfd_pkg::TYPE_ANG:  rec.kind = isfd_pkg::KIND_ANG;
        default:             rec.kind = isfd_pkg::KIND_UNK;
      endcase
    end
    rec.raw_x   = {frame_r[3], frame_r[2]};
    rec.raw_y   = {frame_r[5], frame_r[4]};
    rec.raw_z   = {frame_r[7], frame_r[6]};
    rec.raw_t   = {frame_r[9], frame_r[8]};
    rec.csum_ok = (sum_r == in_rx_byte);
  end

  a_hunt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    hunting_r |-> (idx_r == '0) && (sum_r == '0))
    else $error("assembler hunting with a partial frame");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= isfd_pkg::IDX_W'(isfd_pkg::LAST_IDX))
    else $error("byte index beyond frame end");

endmodule

### design/isfd_queue.sv
// ----------------------------------------------------------------------------
// IMU serial frame decoder - frame record queue
// Short FIFO that decouples the frame assembler from the scaling pipeline.
// ----------------------------------------------------------------------------
module isfd_queue #(
  parameter int DEPTH = isfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  isfd_pkg::frame_rec_t wr_data,
  input  logic                 pop,
  output isfd_pkg::frame_rec_t rd_data,
  output logic                 empty,
  output logic                 full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  isfd_pkg::frame_rec_t mem_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("record written into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("record read from an empty queue");

endmodule

### design/isfd_back.sv
// ----------------------------------------------------------------------------
// IMU serial frame decoder - scaling pipeline
// Three-stage pipeline: axis scaling and reciprocal multiply, quotient
// correction, then sign, offset and the output register.
// ----------------------------------------------------------------------------
module isfd_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  input  isfd_pkg::frame_rec_t                 q_data,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [2:0]                           out_frame_kind,
  output logic signed [isfd_pkg::AXIS_W-1:0]   out_axis_x,
  output logic signed [isfd_pkg::AXIS_W-1:0]   out_axis_y,
  output logic signed [isfd_pkg::AXIS_W-1:0]   out_axis_z,
  output logic signed [isfd_pkg::TEMP_W-1:0]   out_temperature,
  output logic                                 out_checksum_ok
);

  localparam int AW = isfd_pkg::AXIS_W;
  localparam int TW = isfd_pkg::TEMP_W;
  localparam int MW = isfd_pkg::MAG_W;
  localparam int QW = isfd_pkg::QUO_W;

  // The whole pipeline advances together whenever the output slot frees up.
  logic pipe_en;

  logic                       s1_v_r, s2_v_r, out_v_r;
  isfd_pkg::kind_t            s1_kind_r, s2_kind_r, out_kind_r;
  logic signed [AW-1:0]       s1_x_r, s1_y_r, s1_z_r;
  logic signed [AW-1:0]       s2_x_r, s2_y_r, s2_z_r;
  logic signed [AW-1:0]       out_x_r, out_y_r, out_z_r;
  logic                       s1_ck_r, s2_ck_r, out_ck_r;
  logic                       s1_neg_r, s2_neg_r;
  logic [MW-1:0]              s1_mag_r;
  logic [QW-1:0]              s1_qe_r, s2_q_r;
  logic signed [TW-1:0]       out_t_r;

  assign pipe_en = !out_v_r || out_ready;
  assign pop     = pipe_en && !q_empty;

  // Stage 1: axis products and reciprocal estimate of |raw| * 64 / 85.
  logic [isfd_pkg::SCALE_W-1:0]     scale;
  logic signed [isfd_pkg::SCALE_W:0] scale_s;
  logic signed [isfd_pkg::PROD_W-1:0] prod_x, prod_y, prod_z;
  logic [isfd_pkg::RAW_W-1:0]       t_abs;
  logic [MW-1:0]                    t_mag;
  logic [isfd_pkg::RPROD_W-1:0]     t_prod;

  always_comb begin
    case (q_data.kind)
      isfd_pkg::KIND_ACC:  scale = isfd_pkg::SCALE_ACC;
      isfd_pkg::KIND_RATE: scale = isfd_pkg::SCALE_RATE;
      isfd_pkg::KIND_ANG:  scale = isfd_pkg::SCALE_ANG;
      default:             scale = '0;
    endcase
  end

  assign scale_s = $signed({1'b0, scale});
  assign prod_x  = $signed(q_data.raw_x) * scale_s;
  assign prod_y  = $signed(q_data.raw_y) * scale_s;
  assign prod_z  = $signed(q_data.raw_z) * scale_s;

  assign t_abs  = q_data.raw_t[isfd_pkg::RAW_W-1] ? isfd_pkg::RAW_W'(-q_data.raw_t)
                                                   : isfd_pkg::RAW_W'(q_data.raw_t);
  assign t_mag  = {t_abs, isfd_pkg::TEMP_PRESHIFT'(0)};
  assign t_prod = isfd_pkg::RPROD_W'(t_mag) * isfd_pkg::RPROD_W'(isfd_pkg::RECIP_M);

  // Stage 2: the estimate is exact or one short; one compare fixes it.
  logic [MW:0]   rem;
  logic [QW-1:0] q_fix;

  assign rem   = (MW + 1)'(s1_mag_r)
               - (MW + 1)'((MW + 1)'(s1_qe_r) * (MW + 1)'(isfd_pkg::TEMP_DIV));
  assign q_fix = (rem >= (MW + 1)'(isfd_pkg::TEMP_DIV)) ? s1_qe_r + QW'(1) : s1_qe_r;

  // Stage 3: restore the sign and add the offset; a bad frame gives zero.
  logic signed [TW-1:0] t_sgn, t_fin;

  assign t_sgn = s2_neg_r ? -$signed(TW'(s2_q_r)) : $signed(TW'(s2_q_r));
  assign t_fin = (s2_kind_r == isfd_pkg::KIND_BAD) ? '0
               : t_sgn + $signed(TW'(isfd_pkg::TEMP_OFFSET));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (pipe_en) begin
      s1_v_r  <= pop;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_kind_r  <= q_data.kind;
      s1_x_r     <= AW'(prod_x);
      s1_y_r     <= AW'(prod_y);
      s1_z_r     <= AW'(prod_z);
      s1_ck_r    <= q_data.csum_ok;
      s1_neg_r   <= q_data.raw_t[isfd_pkg::RAW_W-1];
      s1_mag_r   <= t_mag;
      s1_qe_r    <= t_prod[isfd_pkg::RECIP_SHIFT +: QW];

      s2_kind_r  <= s1_kind_r;
      s2_x_r     <= s1_x_r;
      s2_y_r     <= s1_y_r;
      s2_z_r     <= s1_z_r;
      s2_ck_r    <= s1_ck_r;
      s2_neg_r   <= s1_neg_r;
      s2_q_r     <= q_fix;

      out_kind_r <= s2_kind_r;
      out_x_r    <= s2_x_r;
      out_y_r    <= s2_y_r;
      out_z_r    <= s2_z_r;
      out_ck_r   <= s2_ck_r;
      out_t_r    <= t_fin;
    end
  end

  assign out_valid       = out_v_r;
  assign out_frame_kind  = out_kind_r;
  assign out_axis_x      = out_x_r;
  assign out_axis_y      = out_y_r;
  assign out_axis_z      = out_z_r;
  assign out_temperature = out_t_r;
  assign out_checksum_ok = out_ck_r;

  a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (s2_q_r <= QW'(isfd_pkg::QUO_MAX)))
    else $error("temperature quotient out of range");

endmodule

### design/imu_serial_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// IMU serial frame decoder - top level
// Cuts an inertial sensor's serial byte stream into 11-byte frames and
// delivers one decoded, scaled result per frame.
// ----------------------------------------------------------------------------
// One byte is accepted per clock cycle while in_ready is high. After reset,
// bytes are dropped until the first 0x55; from then on every 11 bytes form a
// frame, with no resync. The frame assembler stores bytes 0..9 and the running
// checksum, and on the eleventh byte writes a classified record into a short
// queue. A three-stage pipeline scales the axes with constant multipliers and
// turns the raw temperature into 1/256 degC with a reciprocal multiply and one
// correction step; a record passes from the queue through the stage 1, stage 2
// and output registers. The pipeline takes a new record every cycle while the
// output is not held off. The input stalls only when the last byte of a frame
// arrives while the queue is full, which happens only when the result side has
// been held off.
module imu_serial_frame_decoder_top #(
  parameter int QUEUE_DEPTH = isfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_rx_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          out_frame_kind,
  output logic signed [isfd_pkg::AXIS_W-1:0]  out_axis_x,
  output logic signed [isfd_pkg::AXIS_W-1:0]  out_axis_y,
  output logic signed [isfd_pkg::AXIS_W-1:0]  out_axis_z,
  output logic signed [isfd_pkg::TEMP_W-1:0]  out_temperature,
  output logic                                out_checksum_ok
);

  isfd_pkg::frame_rec_t wr_rec;
  isfd_pkg::frame_rec_t rd_rec;
  logic                 push;
  logic                 pop;
  logic                 q_empty;
  logic                 q_full;

  isfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .push       (push),
    .rec        (wr_rec)
  );

  isfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (wr_rec),
    .pop     (pop),
    .rd_data (rd_rec),
    .empty   (q_empty),
    .full    (q_full)
  );

  isfd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (rd_rec),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_kind  (out_frame_kind),
    .out_axis_x      (out_axis_x),
    .out_axis_y      (out_axis_y),
    .out_axis_z      (out_axis_z),
    .out_temperature (out_temperature),
    .out_checksum_ok (out_checksum_ok)
  );

endmodule
